@@ rtl/tab_pkg.sv @@
// tab_pkg: shared types and constants for the triangle adjacency builder.
// Used by tab_front, tab_back and triangle_adjacency_builder; no dependencies.
package tab_pkg;

   localparam int DEF_MAX_VERTICES = 4096;
   localparam int DEF_EDGE_SLOTS   = 16384;

   localparam int POS_W    = 32;
   localparam int IDX_W    = 12;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 2;

   // action codes on the request word
   localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_EMIT  = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd3;

   // status codes on the response word
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_VERT_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EDGE_FULL = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_CORNER = 2'd3;

   // hash multipliers for the edge key
   localparam logic [31:0] HASH_MUL_LO = 32'd2654435761;
   localparam logic [31:0] HASH_MUL_HI = 32'd40503;

   // input queue depth
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_ADD,
      OP_EMIT,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [POS_W-1:0]   pos_x;
      logic [POS_W-1:0]   pos_y;
      logic [POS_W-1:0]   pos_z;
      logic [IDX_W-1:0]   corner_a;
      logic [IDX_W-1:0]   corner_b;
      logic [IDX_W-1:0]   corner_c;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;

   typedef struct packed {
      logic sweeping;
   } back_status_type;

   typedef enum logic [3:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_DISPATCH,
      ST_LD_RD,
      ST_LD_CMP,
      ST_LD_FIN,
      ST_FETCH,
      ST_HASH1,
      ST_HASH2,
      ST_MOD,
      ST_PROBE_RD,
      ST_PROBE_CHK,
      ST_ACT,
      ST_EMIT_A,
      ST_EMIT_B,
      ST_RESP
   } state_type;

endpackage

@@ rtl/tab_front.sv @@
// tab_front: accepts request words, decodes the action and queues them.
// Depends on tab_pkg.
module tab_front
   import tab_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [POS_W-1:0]    req_pos_x,
   input  logic [POS_W-1:0]    req_pos_y,
   input  logic [POS_W-1:0]    req_pos_z,
   input  logic [IDX_W-1:0]    req_corner_a,
   input  logic [IDX_W-1:0]    req_corner_b,
   input  logic [IDX_W-1:0]    req_corner_c,
   input  back_status_type     back_status,
   output queue_out_type       q_out,
   input  logic                q_pop
);

   item_type              queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wptr_ff, wptr_in;
   logic [QPTR_W-1:0]     rptr_ff, rptr_in;
   logic [QCNT_W-1:0]     cnt_ff, cnt_in;
   logic                  accept;
   item_type              new_item;

   always_comb begin
      new_item.pos_x    = req_pos_x;
      new_item.pos_y    = req_pos_y;
      new_item.pos_z    = req_pos_z;
      new_item.corner_a = req_corner_a;
      new_item.corner_b = req_corner_b;
      new_item.corner_c = req_corner_c;
      unique case (req_action)
         ACT_LOAD:  new_item.op = OP_LOAD;
         ACT_ADD:   new_item.op = OP_ADD;
         ACT_EMIT:  new_item.op = OP_EMIT;
         ACT_CLEAR: new_item.op = OP_CLEAR;
         default:   new_item.op = OP_LOAD;
      endcase
   end

   assign req_stall = (cnt_ff == QCNT_W'(QUEUE_DEPTH)) || back_status.sweeping;
   assign accept    = req_valid && !req_stall;

   assign q_out.valid = (cnt_ff != '0);
   assign q_out.item  = queue_ff[rptr_ff];

   always_comb begin
      wptr_in = accept ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = q_pop ? rptr_ff + 1'b1 : rptr_ff;
      cnt_in  = cnt_ff + QCNT_W'(accept) - QCNT_W'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wptr_ff] <= new_item;
      end
   end

endmodule

@@ rtl/tab_back.sv @@
// tab_back: sequencer that runs queued words against the vertex and edge stores
// and drives the registered response word. Depends on tab_pkg.
module tab_back
   import tab_pkg::*;
#(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   parameter int EDGE_SLOTS   = DEF_EDGE_SLOTS
)
(
   input  logic                clock,
   input  logic                reset,
   input  queue_out_type       q_out,
   output logic                q_pop,
   output back_status_type     back_status,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [IDX_W-1:0]    rsp_out_index,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_last
);

   localparam int  AW = $clog2(MAX_VERTICES);
   localparam int  CW = $clog2(MAX_VERTICES + 1);
   localparam int  UW = AW;
   localparam int  XW = (CW > IDX_W) ? CW : IDX_W;
   localparam int  SW = $clog2(EDGE_SLOTS);
   localparam int  PW = $clog2(EDGE_SLOTS + 1);
   localparam bit  HashPow2 = ((EDGE_SLOTS & (EDGE_SLOTS - 1)) == 0);
   // floor(2^32 / EDGE_SLOTS); quotient estimate is low by at most one
   localparam logic [31:0] HashRecip = 32'((64'd1 << 32) / 64'(EDGE_SLOTS));
   // edge entry layout: {valid, cnt, opp1, opp0, hi, lo}
   localparam int  LO_L  = 0;
   localparam int  HI_L  = UW;
   localparam int  OP0_L = 2 * UW;
   localparam int  OP1_L = 2 * UW + IDX_W;
   localparam int  CNT_L = 2 * UW + 2 * IDX_W;
   localparam int  VAL_B = 2 * UW + 2 * IDX_W + 2;
   localparam int  EW    = VAL_B + 1;
   localparam int  PVW   = 3 * POS_W;

   function automatic logic is_nan(input logic [POS_W-1:0] a);
      is_nan = (a[30:23] == 8'hFF) && (a[22:0] != '0);
   endfunction

   function automatic logic comp_eq(input logic [POS_W-1:0] a, input logic [POS_W-1:0] b);
      if (is_nan(a) || is_nan(b)) begin
         comp_eq = 1'b0;
      end else if ((a[30:0] == '0) && (b[30:0] == '0)) begin
         comp_eq = 1'b1;
      end else begin
         comp_eq = (a == b);
      end
   endfunction

   // memories
   logic [PVW-1:0] upos_mem [MAX_VERTICES];
   logic [UW-1:0]  v2u_mem  [MAX_VERTICES];
   logic [EW-1:0]  edge_mem [EDGE_SLOTS];
   logic [PVW-1:0] upos_rd_ff;
   logic [UW-1:0]  v2u_rd_ff;
   logic [EW-1:0]  edge_rd_ff;
   logic           upos_we, upos_re, v2u_we, v2u_re, edge_we, edge_re;
   logic [AW-1:0]  upos_addr, v2u_addr;
   logic [SW-1:0]  edge_addr;
   logic [PVW-1:0] upos_wd;
   logic [UW-1:0]  v2u_wd;
   logic [EW-1:0]  edge_wd;

   // control and datapath registers
   state_type           state_ff, state_in;
   item_type            item_ff, item_in;
   logic [CW-1:0]       vcnt_ff, vcnt_in;
   logic [CW-1:0]       ucnt_ff, ucnt_in;
   logic [CW-1:0]       scan_ff, scan_in;
   logic [SW-1:0]       sweep_ff, sweep_in;
   logic                clr_resp_ff, clr_resp_in;
   logic [STATUS_W-1:0] pend_st_ff, pend_st_in;
   logic [UW-1:0]       u_ff [3];
   logic [UW-1:0]       u_in [3];
   logic [1:0]          fcnt_ff, fcnt_in;
   logic [1:0]          edge_ff, edge_in;
   logic [UW-1:0]       lo_ff, lo_in, hi_ff, hi_in;
   logic [31:0]         pa_ff, pa_in, pb_ff, pb_in;
   logic [31:0]         hash_ff, hash_in;
   logic [31:0]         quo_ff, quo_in;
   logic [31:0]         qd_ff, qd_in;
   logic [1:0]          mcnt_ff, mcnt_in;
   logic [SW-1:0]       slot_ff, slot_in;
   logic [PW-1:0]       probes_ff, probes_in;
   logic                hit_ff, hit_in, free_ff, free_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]    rsp_index_ff, rsp_index_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_last_ff, rsp_last_in;

   // decode helpers
   logic                out_free;
   logic                vfull, corners_ok, pos_match, scan_more;
   logic                e_valid, key_match, last_probe;
   logic [1:0]          e_cnt;
   logic [IDX_W-1:0]    e_opp0, e_opp1;
   logic [IDX_W-1:0]    c_p, own;
   logic [UW-1:0]       ua, ub;
   logic [63:0]         recip_prod;
   logic [31:0]         rem_diff;
   logic [IDX_W-1:0]    nb;
   logic [STATUS_W-1:0] emit_st;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign vfull      = (vcnt_ff >= CW'(MAX_VERTICES));
   assign corners_ok = (XW'(item_ff.corner_a) < XW'(vcnt_ff)) &&
                       (XW'(item_ff.corner_b) < XW'(vcnt_ff)) &&
                       (XW'(item_ff.corner_c) < XW'(vcnt_ff));
   assign scan_more  = (scan_ff < ucnt_ff);
   assign pos_match  = comp_eq(upos_rd_ff[POS_W-1:0], item_ff.pos_x) &&
                       comp_eq(upos_rd_ff[2*POS_W-1:POS_W], item_ff.pos_y) &&
                       comp_eq(upos_rd_ff[PVW-1:2*POS_W], item_ff.pos_z);

   assign e_valid    = edge_rd_ff[VAL_B];
   assign e_cnt      = edge_rd_ff[CNT_L +: 2];
   assign e_opp0     = edge_rd_ff[OP0_L +: IDX_W];
   assign e_opp1     = edge_rd_ff[OP1_L +: IDX_W];
   assign key_match  = (edge_rd_ff[LO_L +: UW] == lo_ff) && (edge_rd_ff[HI_L +: UW] == hi_ff);
   assign last_probe = (probes_ff == PW'(EDGE_SLOTS - 1));

   // corners of the current edge
   always_comb begin
      case (edge_ff)
         2'd0: begin
            c_p = item_ff.corner_a;
            own = item_ff.corner_c;
            ua  = u_ff[0];
            ub  = u_ff[1];
         end
         2'd1: begin
            c_p = item_ff.corner_b;
            own = item_ff.corner_a;
            ua  = u_ff[1];
            ub  = u_ff[2];
         end
         default: begin
            c_p = item_ff.corner_c;
            own = item_ff.corner_b;
            ua  = u_ff[2];
            ub  = u_ff[0];
         end
      endcase
   end

   // neighbor pick on emit
   always_comb begin
      if (hit_ff) begin
         nb      = ((e_cnt > 2'd1) && (e_opp0 == own)) ? e_opp1 : e_opp0;
         emit_st = ST_OK;
      end else begin
         nb      = own;
         emit_st = ST_EDGE_FULL;
      end
   end

   // slot remainder: reciprocal quotient estimate, then one correction
   always_comb begin
      recip_prod = {32'b0, hash_ff} * {32'b0, HashRecip};
      rem_diff   = hash_ff - qd_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_SWEEP: begin
            if (sweep_ff == SW'(EDGE_SLOTS - 1)) begin
               state_in = clr_resp_ff ? ST_RESP : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_out.valid) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (item_ff.op)
               OP_LOAD:  state_in = vfull ? ST_RESP : ST_LD_RD;
               OP_CLEAR: state_in = ST_SWEEP;
               default:  state_in = corners_ok ? ST_FETCH : ST_RESP;
            endcase
         end
         ST_LD_RD:  state_in = scan_more ? ST_LD_CMP : ST_LD_FIN;
         ST_LD_CMP: state_in = pos_match ? ST_LD_FIN : ST_LD_RD;
         ST_LD_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_FETCH: begin
            if (fcnt_ff == 2'd3) begin
               state_in = ST_HASH1;
            end
         end
         ST_HASH1: state_in = ST_HASH2;
         ST_HASH2: state_in = HashPow2 ? ST_PROBE_RD : ST_MOD;
         ST_MOD: begin
            if (mcnt_ff == 2'd2) begin
               state_in = ST_PROBE_RD;
            end
         end
         ST_PROBE_RD: state_in = ST_PROBE_CHK;
         ST_PROBE_CHK: begin
            if (!e_valid || key_match || last_probe) begin
               state_in = (item_ff.op == OP_ADD) ? ST_ACT : ST_EMIT_A;
            end else begin
               state_in = ST_PROBE_RD;
            end
         end
         ST_ACT: begin
            if ((!hit_ff && !free_ff) || (edge_ff == 2'd2)) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_HASH1;
            end
         end
         ST_EMIT_A: begin
            if (out_free) begin
               state_in = ST_EMIT_B;
            end
         end
         ST_EMIT_B: begin
            if (out_free) begin
               state_in = (edge_ff == 2'd2) ? ST_IDLE : ST_HASH1;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      item_in       = item_ff;
      vcnt_in       = vcnt_ff;
      ucnt_in       = ucnt_ff;
      scan_in       = scan_ff;
      sweep_in      = sweep_ff;
      clr_resp_in   = clr_resp_ff;
      pend_st_in    = pend_st_ff;
      u_in          = u_ff;
      fcnt_in       = fcnt_ff;
      edge_in       = edge_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      pa_in         = pa_ff;
      pb_in         = pb_ff;
      hash_in       = hash_ff;
      quo_in        = quo_ff;
      qd_in         = qd_ff;
      mcnt_in       = mcnt_ff;
      slot_in       = slot_ff;
      probes_in     = probes_ff;
      hit_in        = hit_ff;
      free_in       = free_ff;
      rsp_valid_in  = rsp_stall ? rsp_valid_ff : 1'b0;
      rsp_index_in  = rsp_index_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      q_pop         = 1'b0;
      upos_we       = 1'b0;
      upos_re       = 1'b0;
      upos_addr     = AW'(scan_ff);
      upos_wd       = {item_ff.pos_z, item_ff.pos_y, item_ff.pos_x};
      v2u_we        = 1'b0;
      v2u_re        = 1'b0;
      v2u_addr      = AW'(vcnt_ff);
      v2u_wd        = UW'(scan_ff);
      edge_we       = 1'b0;
      edge_re       = 1'b0;
      edge_addr     = slot_ff;
      edge_wd       = edge_rd_ff;

      unique case (state_ff)
         ST_SWEEP: begin
            edge_we   = 1'b1;
            edge_addr = sweep_ff;
            edge_wd   = '0;
            sweep_in  = sweep_ff + 1'b1;
         end
         ST_IDLE: begin
            if (q_out.valid) begin
               q_pop   = 1'b1;
               item_in = q_out.item;
            end
         end
         ST_DISPATCH: begin
            scan_in = '0;
            fcnt_in = '0;
            edge_in = '0;
            unique case (item_ff.op)
               OP_LOAD:  pend_st_in = ST_VERT_FULL;
               OP_CLEAR: begin
                  vcnt_in     = '0;
                  ucnt_in     = '0;
                  sweep_in    = '0;
                  clr_resp_in = 1'b1;
                  pend_st_in  = ST_OK;
               end
               default:  pend_st_in = ST_BAD_CORNER;
            endcase
         end
         ST_LD_RD: begin
            upos_re = scan_more;
         end
         ST_LD_CMP: begin
            if (!pos_match) begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_LD_FIN: begin
            if (out_free) begin
               if (scan_ff == ucnt_ff) begin
                  upos_we = 1'b1;
                  ucnt_in = ucnt_ff + 1'b1;
               end
               v2u_we        = 1'b1;
               vcnt_in       = vcnt_ff + 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_index_in  = IDX_W'(scan_ff);
               rsp_status_in = ST_OK;
               rsp_last_in   = 1'b1;
            end
         end
         ST_FETCH: begin
            fcnt_in = fcnt_ff + 1'b1;
            v2u_re  = (fcnt_ff != 2'd3);
            case (fcnt_ff)
               2'd0:    v2u_addr = AW'(item_ff.corner_a);
               2'd1:    v2u_addr = AW'(item_ff.corner_b);
               default: v2u_addr = AW'(item_ff.corner_c);
            endcase
            if (fcnt_ff != 2'd0) begin
               u_in[fcnt_ff - 2'd1] = v2u_rd_ff;
            end
         end
         ST_HASH1: begin
            lo_in = (ua < ub) ? ua : ub;
            hi_in = (ua < ub) ? ub : ua;
            pa_in = 32'(32'((ua < ub) ? ua : ub) * HASH_MUL_LO);
            pb_in = 32'(32'((ua < ub) ? ub : ua) * HASH_MUL_HI);
         end
         ST_HASH2: begin
            hash_in   = pa_ff ^ pb_ff;
            mcnt_in   = '0;
            slot_in   = SW'(pa_ff ^ pb_ff);
            probes_in = '0;
         end
         ST_MOD: begin
            mcnt_in = mcnt_ff + 1'b1;
            case (mcnt_ff)
               2'd0:    quo_in = recip_prod[63:32];
               2'd1:    qd_in  = 32'(quo_ff * 32'(EDGE_SLOTS));
               default: begin
                  if (rem_diff >= 32'(EDGE_SLOTS)) begin
                     slot_in = SW'(rem_diff - 32'(EDGE_SLOTS));
                  end else begin
                     slot_in = SW'(rem_diff);
                  end
               end
            endcase
         end
         ST_PROBE_RD: begin
            edge_re = 1'b1;
         end
         ST_PROBE_CHK: begin
            if (!e_valid) begin
               hit_in  = 1'b0;
               free_in = 1'b1;
            end else if (key_match) begin
               hit_in  = 1'b1;
               free_in = 1'b0;
            end else if (last_probe) begin
               hit_in  = 1'b0;
               free_in = 1'b0;
            end else begin
               probes_in = probes_ff + 1'b1;
               slot_in   = (slot_ff == SW'(EDGE_SLOTS - 1)) ? '0 : slot_ff + 1'b1;
            end
         end
         ST_ACT: begin
            if (hit_ff) begin
               if (e_cnt < 2'd2) begin
                  edge_we = 1'b1;
                  edge_wd = edge_rd_ff;
                  if (e_cnt == 2'd0) begin
                     edge_wd[OP0_L +: IDX_W] = own;
                  end else begin
                     edge_wd[OP1_L +: IDX_W] = own;
                  end
                  edge_wd[CNT_L +: 2] = e_cnt + 2'd1;
               end
            end else if (free_ff) begin
               edge_we = 1'b1;
               edge_wd = {1'b1, 2'd1, {IDX_W{1'b0}}, own, hi_ff, lo_ff};
            end
            if (!hit_ff && !free_ff) begin
               pend_st_in = ST_EDGE_FULL;
            end else if (edge_ff == 2'd2) begin
               pend_st_in = ST_OK;
            end else begin
               edge_in = edge_ff + 1'b1;
            end
         end
         ST_EMIT_A: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = c_p;
               rsp_status_in = emit_st;
               rsp_last_in   = 1'b0;
            end
         end
         ST_EMIT_B: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = nb;
               rsp_status_in = emit_st;
               rsp_last_in   = (edge_ff == 2'd2);
               edge_in       = edge_ff + 1'b1;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = '0;
               rsp_status_in = pend_st_ff;
               rsp_last_in   = 1'b1;
               clr_resp_in   = 1'b0;
            end
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         clr_resp_ff  <= 1'b0;
         vcnt_ff      <= '0;
         ucnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         clr_resp_ff  <= clr_resp_in;
         vcnt_ff      <= vcnt_in;
         ucnt_ff      <= ucnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      scan_ff       <= scan_in;
      pend_st_ff    <= pend_st_in;
      u_ff          <= u_in;
      fcnt_ff       <= fcnt_in;
      edge_ff       <= edge_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      pa_ff         <= pa_in;
      pb_ff         <= pb_in;
      hash_ff       <= hash_in;
      quo_ff        <= quo_in;
      qd_ff         <= qd_in;
      mcnt_ff       <= mcnt_in;
      slot_ff       <= slot_in;
      probes_ff     <= probes_in;
      hit_ff        <= hit_in;
      free_ff       <= free_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // unique position store
   always_ff @(posedge clock) begin
      if (upos_we) begin
         upos_mem[upos_addr] <= upos_wd;
      end
      if (upos_re) begin
         upos_rd_ff <= upos_mem[upos_addr];
      end
   end

   // vertex to unique id map
   always_ff @(posedge clock) begin
      if (v2u_we) begin
         v2u_mem[v2u_addr] <= v2u_wd;
      end
      if (v2u_re) begin
         v2u_rd_ff <= v2u_mem[v2u_addr];
      end
   end

   // edge hash table
   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[edge_addr] <= edge_wd;
      end
      if (edge_re) begin
         edge_rd_ff <= edge_mem[edge_addr];
      end
   end

   assign back_status.sweeping = (state_ff == ST_SWEEP);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

@@ rtl/triangle_adjacency_builder.sv @@
// triangle_adjacency_builder: top level, front queue plus back sequencer.
// Depends on tab_pkg, tab_front and tab_back.
//
// Usage: one request word per item on req_* (valid/stall), action picks
// load vertex, add face, emit face adjacency or clear. Responses come on
// rsp_* (valid/stall) from an output register; rsp_last marks the final
// word of an item (one word for load/add/clear/errors, six for emit).
// Steps per item, set by the single-port stores:
//   load:  scan of the stored unique positions until one matches, then its word.
//   add/emit: dispatch and corner fetch, then per edge key hashing (with a
//          remainder step when EDGE_SLOTS is not a power of two) and
//          edge-table probes; add then updates the entry per edge and gives
//          its word at the end, emit gives two words per edge.
//   clear: sweep of the edge table, then its word.
// Reset: control clears at once, then the edge table is swept; req_stall
// stays high during any sweep.
// A two-word queue lets new words land while the back end works; when the
// receiver holds rsp_stall, the output word holds and the back end waits.
module triangle_adjacency_builder
   import tab_pkg::*;
#(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   parameter int EDGE_SLOTS   = DEF_EDGE_SLOTS
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [POS_W-1:0]    req_pos_x,
   input  logic [POS_W-1:0]    req_pos_y,
   input  logic [POS_W-1:0]    req_pos_z,
   input  logic [IDX_W-1:0]    req_corner_a,
   input  logic [IDX_W-1:0]    req_corner_b,
   input  logic [IDX_W-1:0]    req_corner_c,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [IDX_W-1:0]    rsp_out_index,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_last
);

   queue_out_type   q_out;
   logic            q_pop;
   back_status_type back_status;

   // front: decode and queue request words
   tab_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_action   (req_action),
      .req_pos_x    (req_pos_x),
      .req_pos_y    (req_pos_y),
      .req_pos_z    (req_pos_z),
      .req_corner_a (req_corner_a),
      .req_corner_b (req_corner_b),
      .req_corner_c (req_corner_c),
      .back_status  (back_status),
      .q_out        (q_out),
      .q_pop        (q_pop)
   );

   // back: dedup scan, edge hashing and probing, response word
   tab_back #(
      .MAX_VERTICES (MAX_VERTICES),
      .EDGE_SLOTS   (EDGE_SLOTS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_out         (q_out),
      .q_pop         (q_pop),
      .back_status   (back_status),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_index (rsp_out_index),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last)
   );

endmodule
